// ===== hw/rtl/door_lock_relay_timer_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the door lock relay timer unit
// Implication checks sampled on clock, masked during reset.
// ----------------------------------------------------------------------------
`ifndef DOOR_LOCK_RELAY_TIMER_UNIT_ASSERT_SVH
`define DOOR_LOCK_RELAY_TIMER_UNIT_ASSERT_SVH

// same-cycle implication
`define DLRT_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("dlrt assertion failed");

// next-cycle implication
`define DLRT_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("dlrt assertion failed");

`endif

// ===== hw/rtl/dlrt_pkg.sv =====
// ----------------------------------------------------------------------------
// dlrt_pkg
// Shared types, register indexes and helpers of the door lock relay timer.
// ----------------------------------------------------------------------------
package dlrt_pkg;

   localparam int CntW = 16;
   localparam int CsrIdxW = 2;

   typedef logic [CntW-1:0] cnt_type;

   localparam logic [CsrIdxW-1:0] CSR_UNLOCK_TIME   = 2'd0;
   localparam logic [CsrIdxW-1:0] CSR_COOLDOWN_TIME = 2'd1;
   localparam logic [CsrIdxW-1:0] CSR_DOOR_WARNING  = 2'd2;
   localparam logic [CsrIdxW-1:0] CSR_BUZZER_PERIOD = 2'd3;

   localparam cnt_type UNLOCK_TIME_RST   = 16'd5000;
   localparam cnt_type COOLDOWN_TIME_RST = 16'd3000;
   localparam cnt_type DOOR_WARNING_RST  = 16'd20000;
   localparam cnt_type BUZZER_PERIOD_RST = 16'd500;
   localparam cnt_type CNT_MAX           = 16'hFFFF;

   typedef struct packed {
      cnt_type unlock_time;
      cnt_type cooldown_time;
      cnt_type door_warning;
      cnt_type buzzer_period;
   } cfg_type;

   typedef struct packed {
      logic unlock_granted;
      logic relay_energized;
      logic buzzer_on;
      logic cooling_down;
   } res_type;

   function automatic cnt_type sat_inc(input cnt_type v);
      return (v == CNT_MAX) ? v : v + 16'd1;
   endfunction

endpackage

// ===== hw/rtl/dlrt_csr.sv =====
// ----------------------------------------------------------------------------
// dlrt_csr
// Configuration register file: four 16-bit timing registers.
// ----------------------------------------------------------------------------
module dlrt_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         wr_en,
   input  logic [dlrt_pkg::CsrIdxW-1:0] wr_index,
   input  dlrt_pkg::cnt_type            wr_data,
   output dlrt_pkg::cfg_type            cfg
);
   import dlrt_pkg::*;

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (wr_index)
            CSR_UNLOCK_TIME:   cfg_in.unlock_time   = wr_data;
            CSR_COOLDOWN_TIME: cfg_in.cooldown_time = wr_data;
            CSR_DOOR_WARNING:  cfg_in.door_warning  = wr_data;
            CSR_BUZZER_PERIOD: cfg_in.buzzer_period = wr_data;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.unlock_time   <= UNLOCK_TIME_RST;
         cfg_ff.cooldown_time <= COOLDOWN_TIME_RST;
         cfg_ff.door_warning  <= DOOR_WARNING_RST;
         cfg_ff.buzzer_period <= BUZZER_PERIOD_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== hw/rtl/dlrt_core.sv =====
// ----------------------------------------------------------------------------
// dlrt_core
// Lock, cooldown and buzzer state with the one-tick update logic.
// ----------------------------------------------------------------------------
module dlrt_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                adv,
   input  logic                door,
   input  logic                req,
   input  dlrt_pkg::cfg_type   cfg,
   output dlrt_pkg::res_type   res
);
   import dlrt_pkg::*;
   `include "door_lock_relay_timer_unit_assert.svh"

   logic    lock_open_ff, lock_open_in;
   logic    in_cd_ff, in_cd_in;
   logic    seen_ff, seen_in;
   logic    buzzer_ff, buzzer_in;
   cnt_type unlock_el_ff, unlock_el_in;
   cnt_type cd_el_ff, cd_el_in;
   cnt_type open_el_ff, open_el_in;
   cnt_type tog_el_ff, tog_el_in;

   logic    grant, lo1, rel, cd1, buz1, tog;
   cnt_type ue, ce, oe, te, ue1;

   always_comb begin
      ue = sat_inc(unlock_el_ff);
      ce = sat_inc(cd_el_ff);
      oe = sat_inc(open_el_ff);
      te = sat_inc(tog_el_ff);

      grant = req && !lock_open_ff && !in_cd_ff;
      lo1   = lock_open_ff || grant;
      ue1   = grant ? '0 : ue;

      rel          = lo1 && ((ue1 >= cfg.unlock_time) || door);
      lock_open_in = lo1 && !rel;
      cd1          = in_cd_ff || rel;
      cd_el_in     = rel ? '0 : ce;
      in_cd_in     = cd1 && !(cd_el_in >= cfg.cooldown_time);
      unlock_el_in = ue1;

      seen_in    = door;
      open_el_in = (door && !seen_ff) ? '0 : oe;
      buz1       = door ? buzzer_ff : 1'b0;

      tog       = seen_in && (open_el_in >= cfg.door_warning) && (te >= cfg.buzzer_period);
      tog_el_in = tog ? '0 : te;
      buzzer_in = tog ? !buz1 : buz1;

      res.unlock_granted  = grant;
      res.relay_energized = lock_open_in;
      res.buzzer_on       = buzzer_in;
      res.cooling_down    = in_cd_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lock_open_ff <= 1'b0;
         in_cd_ff     <= 1'b0;
         seen_ff      <= 1'b0;
         buzzer_ff    <= 1'b0;
         unlock_el_ff <= '0;
         cd_el_ff     <= '0;
         open_el_ff   <= '0;
         tog_el_ff    <= '0;
      end else if (adv) begin
         lock_open_ff <= lock_open_in;
         in_cd_ff     <= in_cd_in;
         seen_ff      <= seen_in;
         buzzer_ff    <= buzzer_in;
         unlock_el_ff <= unlock_el_in;
         cd_el_ff     <= cd_el_in;
         open_el_ff   <= open_el_in;
         tog_el_ff    <= tog_el_in;
      end
   end

   // open door always drops the relay
   `DLRT_ASSERT_NEXT(a_door_releases, adv && door, !lock_open_ff)
   // closed door silences the buzzer
   `DLRT_ASSERT_NEXT(a_closed_quiet, adv && !door, !buzzer_ff)
   // relay and cooldown are exclusive
   `DLRT_ASSERT_NOW(a_open_not_cool, lock_open_ff, !in_cd_ff)
   // state holds without a tick
   `DLRT_ASSERT_NEXT(a_hold_idle, !adv, $stable(unlock_el_ff) && $stable(tog_el_ff))

endmodule

// ===== hw/rtl/door_lock_relay_timer_unit.sv =====
// ----------------------------------------------------------------------------
// door_lock_relay_timer_unit
// Door lock relay timer: one tick item in, one status item out.
// ----------------------------------------------------------------------------
// Path: an accepted item sits in the input register, its result in the result register.
// Throughput: 1 item per cycle while rsp_ is not stalled; state update is one combinational pass.
// Stall on rsp_ back-pressures req_ through the input register only.
// Reset: synchronous; state and timers clear, registers load defaults.
// csr_ writes are always ready and take effect on the next cycle.
module door_lock_relay_timer_unit (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_door_open,
   input  logic                         req_unlock_request,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_unlock_granted,
   output logic                         rsp_relay_energized,
   output logic                         rsp_buzzer_on,
   output logic                         rsp_cooling_down,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [dlrt_pkg::CsrIdxW-1:0] csr_index,
   input  dlrt_pkg::cnt_type            csr_data
);
   import dlrt_pkg::*;

   cfg_type cfg;
   res_type res;

   logic    in_vld_ff, in_vld_in;
   logic    in_door_ff, in_req_ff;
   logic    out_vld_ff, out_vld_in;
   res_type out_ff;
   logic    out_load, adv, in_take;

   assign csr_ready = 1'b1;

   dlrt_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid && csr_ready),
      .wr_index (csr_index),
      .wr_data  (csr_data),
      .cfg      (cfg)
   );

   dlrt_core u_core (
      .clock (clock),
      .reset (reset),
      .adv   (adv),
      .door  (in_door_ff),
      .req   (in_req_ff),
      .cfg   (cfg),
      .res   (res)
   );

   assign out_load  = !out_vld_ff || !rsp_stall;
   assign adv       = in_vld_ff && out_load;
   assign req_stall = in_vld_ff && !out_load;
   assign in_take   = req_valid && !req_stall;
   assign in_vld_in = in_take || (in_vld_ff && !adv);
   assign out_vld_in = out_load ? in_vld_ff : out_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_take) begin
         in_door_ff <= req_door_open;
         in_req_ff  <= req_unlock_request;
      end
      if (adv) begin
         out_ff <= res;
      end
   end

   assign rsp_valid           = out_vld_ff;
   assign rsp_unlock_granted  = out_ff.unlock_granted;
   assign rsp_relay_energized = out_ff.relay_energized;
   assign rsp_buzzer_on       = out_ff.buzzer_on;
   assign rsp_cooling_down    = out_ff.cooling_down;

endmodule

// ===== tb/tb_door_lock_relay_timer_unit.sv =====
// ----------------------------------------------------------------------------
// tb_door_lock_relay_timer_unit
// Self-checking bench for the door lock relay timer. Tick items are fed from a
// queue under random idling and back-pressure, each accepted tick is run
// through a cycle-free model of the timers, and every result item is checked
// field by field in order. Covers register defaults, zero and full-scale
// timer settings, a long open-door stretch with the buzzer running, and
// randomized open/close runs with unlock requests.
// ----------------------------------------------------------------------------
module tb_door_lock_relay_timer_unit;
   import dlrt_pkg::*;

   localparam int WATCHDOG_LIMIT = 3000;
   localparam int DRAIN_CYCLES   = 4;
   localparam int LONG_HOLD      = 80;
   localparam int SOAK_TICKS     = 60;

   typedef struct packed {
      logic door_open;
      logic unlock_request;
   } tick_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic                req_door_open = 1'b0;
   logic                req_unlock_request = 1'b0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic                rsp_unlock_granted;
   logic                rsp_relay_energized;
   logic                rsp_buzzer_on;
   logic                rsp_cooling_down;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [CsrIdxW-1:0]  csr_index = CSR_UNLOCK_TIME;
   cnt_type             csr_data = '0;

   door_lock_relay_timer_unit uut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_door_open       (req_door_open),
      .req_unlock_request  (req_unlock_request),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_unlock_granted  (rsp_unlock_granted),
      .rsp_relay_energized (rsp_relay_energized),
      .rsp_buzzer_on       (rsp_buzzer_on),
      .rsp_cooling_down    (rsp_cooling_down),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   tick_type tick_queue[$];
   res_type  pending_status[$];

   int  ticks_queued = 0;
   int  ticks_taken = 0;
   int  status_checked = 0;
   int  mismatches = 0;
   int  input_blocked = 0;
   int  phases_run = 0;
   int  send_idle_pct = 0;
   int  recv_idle_pct = 0;
   int  holds_asked = 0;
   logic req_fire = 1'b0;

   // timer model state
   cfg_type lock_cfg;
   logic    relay_on, cooling, door_latched, buzz;
   cnt_type unlock_ms, cool_ms, open_ms, toggle_ms;

   function automatic cnt_type bump_ms(input cnt_type v);
      return (&v) ? v : cnt_type'(v + 1'b1);
   endfunction

   function automatic void model_reset();
      lock_cfg.unlock_time   = UNLOCK_TIME_RST;
      lock_cfg.cooldown_time = COOLDOWN_TIME_RST;
      lock_cfg.door_warning  = DOOR_WARNING_RST;
      lock_cfg.buzzer_period = BUZZER_PERIOD_RST;
      relay_on     = 1'b0;
      cooling      = 1'b0;
      door_latched = 1'b0;
      buzz         = 1'b0;
      unlock_ms    = '0;
      cool_ms      = '0;
      open_ms      = '0;
      toggle_ms    = '0;
   endfunction

   function automatic void next_lock_status(input logic door, input logic ask);
      res_type r;
      r = '0;
      unlock_ms = bump_ms(unlock_ms);
      cool_ms   = bump_ms(cool_ms);
      open_ms   = bump_ms(open_ms);
      toggle_ms = bump_ms(toggle_ms);
      if (ask && !relay_on && !cooling) begin
         r.unlock_granted = 1'b1;
         relay_on  = 1'b1;
         unlock_ms = '0;
      end
      if (relay_on && (unlock_ms >= lock_cfg.unlock_time || door)) begin
         relay_on = 1'b0;
         cooling  = 1'b1;
         cool_ms  = '0;
      end
      if (cooling && cool_ms >= lock_cfg.cooldown_time)
         cooling = 1'b0;
      if (door && !door_latched) begin
         door_latched = 1'b1;
         open_ms      = '0;
      end else if (!door) begin
         door_latched = 1'b0;
         buzz         = 1'b0;
      end
      if (door_latched && open_ms >= lock_cfg.door_warning
          && toggle_ms >= lock_cfg.buzzer_period) begin
         toggle_ms = '0;
         buzz      = !buzz;
      end
      r.relay_energized = relay_on;
      r.buzzer_on       = buzz;
      r.cooling_down    = cooling;
      pending_status.push_back(r);
   endfunction

   function automatic void check_field(input string name, input logic want, input logic got);
      if (got !== want) begin
         $error("%s: expected %0b, got %0b", name, want, got);
         mismatches++;
      end
   endfunction

   function automatic void check_status();
      res_type want;
      if (pending_status.size() == 0) begin
         $error("result item with no tick pending");
         mismatches++;
      end else begin
         want = pending_status.pop_front();
         check_field("unlock_granted", want.unlock_granted, rsp_unlock_granted);
         check_field("relay_energized", want.relay_energized, rsp_relay_energized);
         check_field("buzzer_on", want.buzzer_on, rsp_buzzer_on);
         check_field("cooling_down", want.cooling_down, rsp_cooling_down);
         status_checked++;
      end
   endfunction

   // monitor, model and watchdog
   int quiet_cycles = 0;
   always @(posedge clock) begin
      if (reset) begin
         model_reset();
         req_fire <= 1'b0;
         quiet_cycles = 0;
      end else begin
         req_fire <= req_valid && !req_stall;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_UNLOCK_TIME:   lock_cfg.unlock_time   = csr_data;
               CSR_COOLDOWN_TIME: lock_cfg.cooldown_time = csr_data;
               CSR_DOOR_WARNING:  lock_cfg.door_warning  = csr_data;
               CSR_BUZZER_PERIOD: lock_cfg.buzzer_period = csr_data;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            next_lock_status(req_door_open, req_unlock_request);
            ticks_taken++;
         end
         if (req_valid && req_stall)
            input_blocked++;
         if (rsp_valid && !rsp_stall)
            check_status();
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no item moved in %0d cycles", WATCHDOG_LIMIT);
            $display("door_lock_relay_timer_unit verification failed");
            $finish;
         end
      end
   end

   // tick driver
   int send_gap = 0;
   always @(negedge clock) begin
      tick_type t;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (tick_queue.size() != 0 && $urandom_range(0, 99) < send_idle_pct) begin
            send_gap = $urandom_range(0, 10);
            req_valid <= 1'b0;
         end else if (tick_queue.size() != 0) begin
            t = tick_queue.pop_front();
            req_valid          <= 1'b1;
            req_door_open      <= t.door_open;
            req_unlock_request <= t.unlock_request;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result receiver
   int stall_left = 0;
   int hold_left = 0;
   int holds_done = 0;
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (holds_done < holds_asked) begin
         holds_done++;
         hold_left = LONG_HOLD - 1;
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if ($urandom_range(0, 99) < recv_idle_pct) begin
         stall_left = $urandom_range(0, 10);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic write_reg(input logic [CsrIdxW-1:0] idx, input cnt_type value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_timers(input cnt_type ut, input cnt_type ct, input cnt_type dw,
                             input cnt_type bp);
      write_reg(CSR_UNLOCK_TIME, ut);
      write_reg(CSR_COOLDOWN_TIME, ct);
      write_reg(CSR_DOOR_WARNING, dw);
      write_reg(CSR_BUZZER_PERIOD, bp);
      phases_run++;
   endtask

   task automatic push_tick(input logic door, input logic ask);
      tick_queue.push_back('{door_open: door, unlock_request: ask});
      ticks_queued++;
   endtask

   task automatic wait_drained();
      while (ticks_taken != ticks_queued || pending_status.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   function automatic cnt_type pick_ms();
      case ($urandom_range(0, 11))
         0:       return '0;
         1:       return CNT_MAX;
         2, 3, 4: return cnt_type'($urandom_range(1, 4));
         default: return cnt_type'($urandom_range(0, 30));
      endcase
   endfunction

   function automatic int pick_idle_pct();
      case ($urandom_range(0, 2))
         0:       return 0;
         1:       return 8;
         default: return 25;
      endcase
   endfunction

   // open/close runs of random length with requests sprinkled in
   task automatic door_runs(input int count, input int ask_pct);
      logic door;
      int   run;
      while (count > 0) begin
         door = 1'($urandom_range(0, 1));
         run  = $urandom_range(1, 25);
         for (int i = 0; i < run && count > 0; i++) begin
            push_tick(door, $urandom_range(0, 99) < ask_pct);
            count--;
         end
      end
   endtask

   initial begin
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      // register defaults
      send_idle_pct = 25;
      recv_idle_pct = 25;
      push_tick(1'b0, 1'b1);
      push_tick(1'b0, 1'b0);
      push_tick(1'b1, 1'b0);
      push_tick(1'b0, 1'b1);
      wait_drained();

      // short timers: expiry, refusals, door open at grant, buzzer, silence
      set_timers(16'd3, 16'd2, 16'd2, 16'd1);
      push_tick(1'b0, 1'b0);
      push_tick(1'b0, 1'b1);
      push_tick(1'b0, 1'b1);
      push_tick(1'b0, 1'b0);
      push_tick(1'b0, 1'b0);
      push_tick(1'b0, 1'b1);
      push_tick(1'b0, 1'b0);
      push_tick(1'b0, 1'b1);
      push_tick(1'b1, 1'b1);
      repeat (5) push_tick(1'b1, 1'b0);
      push_tick(1'b0, 1'b0);
      wait_drained();

      // all timers zero
      set_timers('0, '0, '0, '0);
      push_tick(1'b0, 1'b1);
      push_tick(1'b0, 1'b1);
      repeat (3) push_tick(1'b1, 1'b1);
      push_tick(1'b0, 1'b0);
      wait_drained();

      for (int p = 0; p < 5; p++) begin
         set_timers(pick_ms(), pick_ms(), pick_ms(), pick_ms());
         send_idle_pct = pick_idle_pct();
         recv_idle_pct = pick_idle_pct();
         if (p == 2) begin
            send_idle_pct = 0;
            door_runs(130, $urandom_range(10, 60));
            holds_asked++;
         end else begin
            door_runs(130, $urandom_range(10, 60));
         end
         wait_drained();
      end

      // long open door: buzzer keeps toggling, relay timers at full scale
      send_idle_pct = 0;
      recv_idle_pct = 0;
      set_timers(CNT_MAX, CNT_MAX, 16'd20, 16'd3);
      push_tick(1'b0, 1'b0);
      repeat (SOAK_TICKS) push_tick(1'b1, $urandom_range(0, 99) < 5);
      wait_drained();

      // tail without idling
      set_timers(pick_ms(), pick_ms(), pick_ms(), pick_ms());
      door_runs(150, $urandom_range(10, 60));
      wait_drained();

      if (pending_status.size() != 0) begin
         $error("%0d expected result items never arrived", pending_status.size());
         mismatches++;
      end
      $display("ran %0d ticks over %0d timer settings, %0d results compared",
               ticks_taken, phases_run, status_checked);
      $display("input held off by back-pressure for %0d cycles, %0d mismatches",
               input_blocked, mismatches);
      if (mismatches == 0)
         $display("door_lock_relay_timer_unit verification clean");
      else
         $display("door_lock_relay_timer_unit verification failed");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/dlrt_pkg.sv
hw/rtl/dlrt_csr.sv
hw/rtl/dlrt_core.sv
hw/rtl/door_lock_relay_timer_unit.sv
tb/tb_door_lock_relay_timer_unit.sv
